[hw/rtl/swpd_pkg.sv]
// shared constants and codes for the sync word packet deframer
package swpd_pkg;

    localparam logic [7:0] SYNC_A = 8'hFF;
    localparam logic [7:0] SYNC_B = 8'hAA;

    localparam int HEADER_BYTES = 6;
    localparam int POS_W        = 15;
    localparam int END_W        = 16;
    localparam int COUNT_W      = 14;
    localparam int NUMBER_W     = 13;
    localparam int HELD_W       = 40;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

endpackage

[hw/rtl/swpd_byte_if.sv]
// received byte channel
interface swpd_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

[hw/rtl/swpd_item_if.sv]
// decoded item channel
interface swpd_item_if;

    logic                              valid;
    logic                              ready;
    logic [1:0]                        item_kind;
    logic [15:0]                       depth_index;
    logic signed [15:0]                temp_centi;
    logic [15:0]                       drive_centivolts;
    logic [15:0]                       sample_value;
    logic [swpd_pkg::NUMBER_W-1:0]     sample_number;
    logic                              checksum_ok;

    modport source (
        output valid, output item_kind, output depth_index, output temp_centi,
        output drive_centivolts, output sample_value, output sample_number,
        output checksum_ok, input ready
    );
    modport sink (
        input valid, input item_kind, input depth_index, input temp_centi,
        input drive_centivolts, input sample_value, input sample_number,
        input checksum_ok, output ready
    );

endinterface

[hw/rtl/sync_word_packet_deframer_unit.sv]
// sync word packet deframer top level: sync hunt, header and sample decode, xor check
//
// channel    dir  handshake      payload
// rx         in   valid/ready    rx_byte
// item       out  valid/ready    item_kind, header fields, sample fields, checksum_ok
// cfg        in   cfg_we         cfg_data (sample_count)
//
// one word per cycle unless rx stalls; each accepted word is decoded in the cycle
// it is taken and its result, if any, appears in the output register on the next cycle
// rx stalls only while a result sits in the output register and item.ready is low
// reset clears the hunt state, payload position and checksum; sample_count resets to 5000
module sync_word_packet_deframer_unit #(
    parameter int MAX_SAMPLES = 8192
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [swpd_pkg::COUNT_W-1:0]    cfg_data,
    swpd_byte_if.sink                       rx,
    swpd_item_if.source                     item
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_FF   = 2'd1;
    localparam logic [1:0] PH_FFFF = 2'd2;

    localparam logic [swpd_pkg::POS_W-1:0] MAX_CNT = swpd_pkg::POS_W'(MAX_SAMPLES);
    localparam logic [swpd_pkg::POS_W-1:0] HDR_LAST =
        swpd_pkg::POS_W'(swpd_pkg::HEADER_BYTES - 1);
    localparam logic [swpd_pkg::POS_W-1:0] HDR_BYTES =
        swpd_pkg::POS_W'(swpd_pkg::HEADER_BYTES);

    logic [swpd_pkg::COUNT_W-1:0]   count_reg;
    logic [1:0]                     phase_reg, phase_next;
    logic                           in_payload_reg, in_payload_next;
    logic [swpd_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [7:0]                     xor_reg, xor_next;
    logic [swpd_pkg::HELD_W-1:0]    held_reg, held_next;

    logic                           out_valid_reg, out_valid_next;
    logic [1:0]                     kind_reg, kind_next;
    logic [15:0]                    depth_reg, depth_next;
    logic [15:0]                    temp_reg, temp_next;
    logic [15:0]                    drive_reg, drive_next;
    logic [15:0]                    sample_reg, sample_next;
    logic [swpd_pkg::NUMBER_W-1:0]  number_reg, number_next;
    logic                           ok_reg, ok_next;

    logic                           take;
    logic [7:0]                     b;
    logic [swpd_pkg::POS_W-1:0]     count_ext;
    logic [swpd_pkg::POS_W-1:0]     eff_count;
    logic [swpd_pkg::END_W-1:0]     end_pos;
    logic                           at_end;
    logic [swpd_pkg::POS_W-1:0]     pos_rel;

    assign rx.ready = !out_valid_reg || item.ready;
    assign take     = rx.valid && rx.ready;
    assign b        = rx.rx_byte;

    // clamp the count into 1..MAX_SAMPLES
    assign count_ext = swpd_pkg::POS_W'(count_reg);
    always_comb
    begin
        if (count_ext == '0)
            eff_count = swpd_pkg::POS_W'(1);
        else if (count_ext > MAX_CNT)
            eff_count = MAX_CNT;
        else
            eff_count = count_ext;
    end

    assign end_pos = swpd_pkg::END_W'(swpd_pkg::HEADER_BYTES) + {eff_count, 1'b0};
    assign at_end  = swpd_pkg::END_W'(pos_reg) >= end_pos;
    assign pos_rel = pos_reg - HDR_BYTES;

    always_comb
    begin
        phase_next      = phase_reg;
        in_payload_next = in_payload_reg;
        pos_next        = pos_reg;
        xor_next        = xor_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg && !item.ready;
        kind_next       = kind_reg;
        depth_next      = depth_reg;
        temp_next       = temp_reg;
        drive_next      = drive_reg;
        sample_next     = sample_reg;
        number_next     = number_reg;
        ok_next         = ok_reg;

        if (take)
        begin
            if (!in_payload_reg)
            begin
                if (phase_reg == PH_FFFF && b == swpd_pkg::SYNC_B)
                begin
                    phase_next      = PH_HUNT;
                    in_payload_next = 1'b1;
                    pos_next        = '0;
                    xor_next        = '0;
                end
                else if (b == swpd_pkg::SYNC_A)
                    phase_next = (phase_reg == PH_HUNT) ? PH_FF : PH_FFFF;
                else
                    phase_next = PH_HUNT;
            end
            else if (at_end)
            begin
                out_valid_next  = 1'b1;
                kind_next       = swpd_pkg::KIND_END;
                depth_next      = '0;
                temp_next       = '0;
                drive_next      = '0;
                sample_next     = '0;
                number_next     = '0;
                ok_next         = (xor_reg == b);
                in_payload_next = 1'b0;
                pos_next        = '0;
                phase_next      = PH_HUNT;
            end
            else
            begin
                xor_next  = xor_reg ^ b;
                pos_next  = pos_reg + swpd_pkg::POS_W'(1);
                held_next = {held_reg[swpd_pkg::HELD_W-9:0], b};
                if (pos_reg == HDR_LAST)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = swpd_pkg::KIND_HEADER;
                    depth_next     = held_reg[39:24];
                    temp_next      = held_reg[23:8];
                    drive_next     = {held_reg[7:0], b};
                    sample_next    = '0;
                    number_next    = '0;
                    ok_next        = 1'b0;
                end
                else if (pos_reg > HDR_LAST && pos_rel[0])
                begin
                    out_valid_next = 1'b1;
                    kind_next      = swpd_pkg::KIND_SAMPLE;
                    depth_next     = '0;
                    temp_next      = '0;
                    drive_next     = '0;
                    sample_next    = {held_reg[7:0], b};
                    number_next    = pos_rel[swpd_pkg::NUMBER_W:1];
                    ok_next        = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= swpd_pkg::COUNT_W'(5000);
            phase_reg      <= PH_HUNT;
            in_payload_reg <= 1'b0;
            pos_reg        <= '0;
            xor_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                count_reg <= cfg_data;
            phase_reg      <= phase_next;
            in_payload_reg <= in_payload_next;
            pos_reg        <= pos_next;
            xor_reg        <= xor_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg   <= held_next;
        kind_reg   <= kind_next;
        depth_reg  <= depth_next;
        temp_reg   <= temp_next;
        drive_reg  <= drive_next;
        sample_reg <= sample_next;
        number_reg <= number_next;
        ok_reg     <= ok_next;
    end

    assign item.valid            = out_valid_reg;
    assign item.item_kind        = kind_reg;
    assign item.depth_index      = depth_reg;
    assign item.temp_centi       = temp_reg;
    assign item.drive_centivolts = drive_reg;
    assign item.sample_value     = sample_reg;
    assign item.sample_number    = number_reg;
    assign item.checksum_ok      = ok_reg;

`ifndef ASSERT_OFF
    a_hunt_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_payload_reg |-> pos_reg == '0)
        else $error("payload position nonzero while hunting");

    a_payload_phase_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> phase_reg == PH_HUNT)
        else $error("sync phase left set inside a payload");

    a_end_leaves_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_payload_reg && at_end) |=>
            (!in_payload_reg && out_valid_reg && kind_reg == swpd_pkg::KIND_END))
        else $error("checksum word did not close the packet");
`endif

endmodule

[tb/sv/swpd_item_checker.sv]
// deframer checker: predicts decoded items from accepted words and compares them
module swpd_item_checker #(
    parameter int MAX_SAMPLES = 8192
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [swpd_pkg::COUNT_W-1:0]    cfg_data,
    swpd_byte_if                            rx,
    swpd_item_if                            item,
    output int                              errors,
    output int                              in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_SAMPLES = 5000;

    typedef enum logic [1:0] {
        HUNT_IDLE,
        HUNT_FF,
        HUNT_FF_FF
    } hunt_t;

    typedef struct packed {
        logic [1:0]                    kind;
        logic [15:0]                   depth;
        logic signed [15:0]            temp;
        logic [15:0]                   drive;
        logic [15:0]                   sample;
        logic [swpd_pkg::NUMBER_W-1:0] number;
        logic                          ok;
    } item_t;

    hunt_t                        hunt;
    logic                         in_packet;
    logic [swpd_pkg::POS_W-1:0]   position;
    logic [7:0]                   running_xor;
    logic [swpd_pkg::HELD_W-1:0]  held;
    logic [swpd_pkg::COUNT_W-1:0] samples_per_packet;
    item_t                        expected_items[$];
    item_t                        predicted;
    item_t                        oldest;

    function automatic bit decode_byte(input logic [7:0] b, output item_t res);
        int unsigned n;
        int unsigned span;
        int unsigned pos;
        res = '0;
        if (!in_packet)
        begin
            if (hunt == HUNT_FF_FF && b == swpd_pkg::SYNC_B)
            begin
                hunt = HUNT_IDLE;
                in_packet = 1'b1;
                position = '0;
                running_xor = '0;
            end
            else if (b == swpd_pkg::SYNC_A)
                hunt = (hunt == HUNT_IDLE) ? HUNT_FF : HUNT_FF_FF;
            else
                hunt = HUNT_IDLE;
            return 1'b0;
        end
        n = samples_per_packet;
        if (n == 0)
            n = 1;
        if (n > MAX_SAMPLES)
            n = MAX_SAMPLES;
        span = swpd_pkg::HEADER_BYTES + 2 * n;
        pos = position;
        if (pos >= span)
        begin
            res.kind = swpd_pkg::KIND_END;
            res.ok = (running_xor == b);
            in_packet = 1'b0;
            position = '0;
            hunt = HUNT_IDLE;
            return 1'b1;
        end
        running_xor = running_xor ^ b;
        position = swpd_pkg::POS_W'(pos + 1);
        if (pos < swpd_pkg::HEADER_BYTES - 1)
        begin
            held = {held[swpd_pkg::HELD_W-9:0], b};
            return 1'b0;
        end
        if (pos == swpd_pkg::HEADER_BYTES - 1)
        begin
            res.kind = swpd_pkg::KIND_HEADER;
            res.depth = held[39:24];
            res.temp = held[23:8];
            res.drive = {held[7:0], b};
            return 1'b1;
        end
        if (((pos - swpd_pkg::HEADER_BYTES) & 1) == 0)
        begin
            held = swpd_pkg::HELD_W'(b);
            return 1'b0;
        end
        res.kind = swpd_pkg::KIND_SAMPLE;
        res.sample = {held[7:0], b};
        res.number = swpd_pkg::NUMBER_W'((pos - swpd_pkg::HEADER_BYTES) >> 1);
        return 1'b1;
    endfunction

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunt = HUNT_IDLE;
            in_packet = 1'b0;
            position = '0;
            running_xor = '0;
            held = '0;
            samples_per_packet = swpd_pkg::COUNT_W'(RESET_SAMPLES);
            expected_items.delete();
            errors = 0;
            in_flight <= 0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                if (decode_byte(rx.rx_byte, predicted))
                    expected_items.push_back(predicted);
            end
            if (item.valid && item.ready)
            begin
                if (expected_items.size() == 0)
                begin
                    $error("item of kind %0d arrived with none expected", item.item_kind);
                    errors++;
                end
                else
                begin
                    oldest = expected_items.pop_front();
                    compare_field("item_kind", oldest.kind, item.item_kind);
                    compare_field("depth_index", oldest.depth, item.depth_index);
                    compare_field("temp_centi", $signed(oldest.temp), $signed(item.temp_centi));
                    compare_field("drive_centivolts", oldest.drive, item.drive_centivolts);
                    compare_field("sample_value", oldest.sample, item.sample_value);
                    compare_field("sample_number", oldest.number, item.sample_number);
                    compare_field("checksum_ok", oldest.ok, item.checksum_ok);
                end
            end
            if (cfg_we)
                samples_per_packet = cfg_data;
            in_flight <= expected_items.size();
        end
    end

endmodule

[tb/sv/sync_word_packet_deframer_unit_tb.sv]
// deframer testbench top: clock, reset, word and sample count stimulus, verdict
module sync_word_packet_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SAMPLES  = 8192;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 1650;
    localparam int SETTLE       = 4;

    localparam logic [7:0] LEAD_IN [10] = '{
        8'h00, 8'hFF, 8'hAA, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hAA
    };
    localparam logic [7:0] FIRST_PAYLOAD [10] = '{
        8'h00, 8'h00, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00
    };

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [swpd_pkg::COUNT_W-1:0] cfg_data;
    int                           mismatches;
    int                           items_in_flight;
    int                           idle_cycles;
    int                           hold_requests;
    int                           holds_done;
    int                           packet_bytes;
    bit                           steady_sender;
    logic [7:0]                   frame_xor;

    swpd_byte_if rx_ch ();
    swpd_item_if item_ch ();

    sync_word_packet_deframer_unit #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .rx       (rx_ch),
        .item     (item_ch)
    );

    swpd_item_checker #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) item_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .rx        (rx_ch),
        .item      (item_ch),
        .errors    (mismatches),
        .in_flight (items_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((rx_ch.valid && rx_ch.ready) || (item_ch.valid && item_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
        $display("sync_word_packet_deframer_unit_tb: errors");
        $finish;
    end

    // item receiver: bursts, random stalls, long stalls and requested hold-offs
    initial
    begin
        int r;
        int run;
        item_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (holds_done != hold_requests)
            begin
                holds_done++;
                item_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                run = $urandom_range(4, 40);
                if (r < 30)
                begin
                    item_ch.ready <= 1'b1;
                    repeat (run) @(posedge clk);
                end
                else if (r < 92)
                begin
                    repeat (run)
                    begin
                        item_ch.ready <= ($urandom_range(0, 3) != 0);
                        @(posedge clk);
                    end
                end
                else
                begin
                    item_ch.ready <= 1'b0;
                    repeat ($urandom_range(15, 40)) @(posedge clk);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady_sender)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
    endtask

    task automatic send_sync();
        send_byte(swpd_pkg::SYNC_A);
        send_byte(swpd_pkg::SYNC_A);
        send_byte(swpd_pkg::SYNC_B);
        frame_xor = '0;
    endtask

    task automatic send_payload_byte(input logic [7:0] b);
        frame_xor = frame_xor ^ b;
        send_byte(b);
    endtask

    // stray words, biased toward sync fragments
    task automatic send_noise(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                send_byte(swpd_pkg::SYNC_A);
            else if (r < 4)
                send_byte(swpd_pkg::SYNC_B);
            else
                send_byte(8'($urandom));
        end
    endtask

    task automatic send_packet(input int samples, input bit corrupt);
        send_sync();
        repeat (swpd_pkg::HEADER_BYTES + 2 * samples) send_payload_byte(pick_byte());
        if (corrupt)
            send_byte(frame_xor ^ 8'($urandom_range(1, 255)));
        else
            send_byte(frame_xor);
        packet_bytes += 4 + swpd_pkg::HEADER_BYTES + 2 * samples;
    endtask

    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        do @(posedge clk); while (items_in_flight != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(input logic [swpd_pkg::COUNT_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int r;
        int samples;
        logic [swpd_pkg::COUNT_W-1:0] count;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        rx_ch.valid <= 1'b0;
        rx_ch.rx_byte <= '0;
        steady_sender = 1'b0;
        frame_xor = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // broken sync prefixes, then a packet under the reset count cut short
        foreach (LEAD_IN[i])
            send_byte(LEAD_IN[i]);
        frame_xor = '0;
        foreach (FIRST_PAYLOAD[i])
            send_payload_byte(FIRST_PAYLOAD[i]);
        wait_idle();
        write_count(swpd_pkg::COUNT_W'(1));
        send_byte(frame_xor);

        // receiver holds off while packets keep coming
        wait_idle();
        write_count(swpd_pkg::COUNT_W'(8));
        hold_requests++;
        send_packet(8, 1'b0);
        send_packet(8, 1'b1);

        packet_bytes = 0;
        while (packet_bytes < RANDOM_BYTES)
        begin
            wait_idle();
            r = $urandom_range(0, 99);
            if (r < 70)
                count = swpd_pkg::COUNT_W'($urandom_range(1, 6));
            else if (r < 80)
                count = '0;
            else
                count = swpd_pkg::COUNT_W'($urandom_range(7, 24));
            write_count(count);
            samples = (count == 0) ? 1 : int'(count);
            steady_sender = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 3) == 0)
                    send_noise($urandom_range(1, 6));
                send_packet(samples, $urandom_range(0, 3) == 0);
            end
        end
        steady_sender = 1'b0;

        // widest count, changed inside the packet
        wait_idle();
        write_count(swpd_pkg::COUNT_W'(MAX_SAMPLES));
        send_sync();
        repeat (swpd_pkg::HEADER_BYTES + 20) send_payload_byte(pick_byte());
        wait_idle();
        write_count(swpd_pkg::COUNT_W'(2));
        send_byte(frame_xor);

        // count above the maximum, then cut short inside the packet
        wait_idle();
        write_count('1);
        send_sync();
        repeat (swpd_pkg::HEADER_BYTES + 20) send_payload_byte(pick_byte());
        wait_idle();
        write_count(swpd_pkg::COUNT_W'(3));
        send_byte(frame_xor);

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("sync_word_packet_deframer_unit_tb: clean");
        else
            $display("sync_word_packet_deframer_unit_tb: errors");
        $finish;
    end

endmodule
